>>> design/mpsp_pkg.sv
package mpsp_pkg;

  localparam int MemDepth = 65536;
  localparam int MemAw = $clog2(MemDepth);
  localparam int Channels = 32;
  localparam int ChW = (Channels > 1) ? $clog2(Channels) : 1;
  localparam logic [17:0] StepConst = 18'd176384;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;
  localparam logic [1:0] MODE_LOAD  = 2'd3;

  localparam logic [4:0] REG_START_HI = 5'd0;
  localparam logic [4:0] REG_START_LO = 5'd1;
  localparam logic [4:0] REG_PITCH    = 5'd2;
  localparam logic [4:0] REG_END_LO   = 5'd3;
  localparam logic [4:0] REG_END_HI   = 5'd4;

  localparam logic CFG_OUTPUT_RATE = 1'b0;
  localparam logic CFG_ROM_WORDS   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CH_READ,
    ST_CH_ACC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic div_start;
    logic div_commit;
    logic ch_clear;
    logic ch_read;
    logic ch_update;
    logic sum_clear;
    logic emit_tick;
  } ctrl_t;

  typedef struct packed {
    logic div_done;
    logic ch_last;
  } stat_t;

endpackage

>>> design/mpsp_ctrl.sv
module mpsp_ctrl
  import mpsp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  logic   pitch_write,
  input  logic   tick,
  input  stat_t  stat,
  output logic   busy,
  output ctrl_t  ctrl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (start && pitch_write) begin
          ctrl.div_start = 1'b1;
          state_next = ST_DIV;
        end else if (start && tick) begin
          ctrl.ch_clear = 1'b1;
          ctrl.sum_clear = 1'b1;
          state_next = ST_CH_READ;
        end
      end
      ST_DIV: begin
        if (stat.div_done) begin
          ctrl.div_commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_CH_READ: begin
        ctrl.ch_read = 1'b1;
        state_next = ST_CH_ACC;
      end
      ST_CH_ACC: begin
        ctrl.ch_update = 1'b1;
        state_next = stat.ch_last ? ST_DONE : ST_CH_READ;
      end
      ST_DONE: begin
        ctrl.emit_tick = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> design/mpsp_datapath.sv
module mpsp_datapath
  import mpsp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [1:0]         mode,
  input  logic [10:0]        offset,
  input  logic [15:0]        write_data,
  input  logic [15:0]        load_address,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [16:0]        cfg_data,
  input  ctrl_t              ctrl,
  output stat_t              stat,
  output logic               strobe,
  output logic               is_sample,
  output logic [15:0]        read_data,
  output logic signed [17:0] mixed_sample
);

  logic [16:0] output_rate, rom_words;
  logic [15:0] status_word;
  logic [23:0] start_address [Channels];
  logic [23:0] end_address [Channels];
  logic [39:0] play_position [Channels];
  logic [39:0] pitch_step [Channels];
  logic [Channels-1:0] key_on;
  logic [15:0] sample_memory [MemDepth];

  // latched item fields for multicycle work
  logic [ChW-1:0] pch;
  logic [4:0] ch_cnt;
  logic [ChW-1:0] ch;
  logic [15:0] mem_q;
  logic in_range;
  logic [24:0] addr_q;
  logic signed [22:0] sum;

  logic [4:0] o_ch, o_reg;
  logic ch_ok;
  assign o_ch = offset[9:5];
  assign o_reg = offset[4:0];
  assign ch_ok = ({27'd0, o_ch} < Channels);

  // restoring divider: 38-bit numerator, one quotient bit per cycle
  logic [37:0] num;
  logic [16:0] rem;
  logic [17:0] rem_try;
  logic [5:0] div_cnt;
  assign rem_try = {rem, num[37]} - {1'b0, output_rate};
  assign stat.div_done = (div_cnt == 6'd0);

  always_ff @(posedge clk) begin
    if (ctrl.div_start) begin
      num <= ({20'd0, StepConst} * {25'd0, write_data[12:0]}) << write_data[15:13];
      rem <= '0;
      div_cnt <= 6'd38;
    end else if (div_cnt != 6'd0) begin
      if (!rem_try[17]) begin
        rem <= rem_try[16:0];
        num <= {num[36:0], 1'b1};
      end else begin
        rem <= {rem[15:0], num[37]};
        num <= {num[36:0], 1'b0};
      end
      div_cnt <= div_cnt - 6'd1;
    end
  end

  // play address carries into bit 24, no wrap
  logic [24:0] addr;
  logic [39:0] pos_next;
  assign ch = ch_cnt[ChW-1:0];
  assign stat.ch_last = ({27'd0, ch_cnt} == Channels - 1);
  assign addr = {1'b0, start_address[ch]} + {1'b0, play_position[ch][39:16]};
  assign pos_next = play_position[ch] + pitch_step[ch];

  always_ff @(posedge clk) begin
    if (accept && mode == MODE_LOAD && {8'd0, load_address} < MemDepth) begin
      sample_memory[load_address[MemAw-1:0]] <=
          write_data[15] ? (write_data ^ 16'h7fff) : write_data;
    end
    if (ctrl.ch_read) begin
      mem_q <= sample_memory[addr[MemAw-1:0]];
      addr_q <= addr;
      in_range <= ({7'd0, addr} < MemDepth);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) pch <= o_ch[ChW-1:0];
    if (ctrl.ch_clear) ch_cnt <= '0;
    else if (ctrl.ch_update) ch_cnt <= ch_cnt + 5'd1;
    if (ctrl.sum_clear) sum <= '0;
    else if (ctrl.ch_update && key_on[ch] && in_range)
      sum <= sum + {{7{mem_q[15]}}, mem_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      output_rate <= 17'd44100;
      rom_words <= 17'd65536;
      status_word <= '0;
      key_on <= '0;
      for (int i = 0; i < Channels; i++) begin
        start_address[i] <= '0;
        end_address[i] <= '0;
        play_position[i] <= '0;
        pitch_step[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_OUTPUT_RATE) output_rate <= cfg_data;
        else rom_words <= cfg_data;
      end
      if (accept && mode == MODE_WRITE) begin
        if (offset == 11'd0) status_word <= write_data;
        if (offset[10] && ch_ok) begin
          unique case (o_reg)
            REG_START_HI: start_address[o_ch[ChW-1:0]][23:16] <= write_data[15:8];
            REG_START_LO: begin
              start_address[o_ch[ChW-1:0]][15:0] <= write_data;
              play_position[o_ch[ChW-1:0]] <= '0;
              key_on[o_ch[ChW-1:0]] <= 1'b1;
            end
            REG_END_LO: end_address[o_ch[ChW-1:0]][15:0] <= write_data;
            REG_END_HI: end_address[o_ch[ChW-1:0]][23:16] <= write_data[7:0];
            default: ;
          endcase
        end
      end
      if (ctrl.div_commit)
        pitch_step[pch] <= (output_rate == '0) ? 40'd0 : {2'd0, num};
      if (ctrl.ch_update && key_on[ch]) begin
        if (addr_q > {8'd0, rom_words} || addr_q > {1'b0, end_address[ch]}) begin
          key_on[ch] <= 1'b0;
          play_position[ch] <= '0;
        end else begin
          play_position[ch] <= pos_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctrl.emit_tick || (accept && mode == MODE_READ);
    end
    is_sample <= ctrl.emit_tick;
    read_data <= (!ctrl.emit_tick && offset == 11'd0) ? status_word : 16'd0;
    mixed_sample <= ctrl.emit_tick ? sum[20:3] : 18'sd0;
  end

endmodule

>>> design/multichannel_pcm_sample_player_top.sv
// Thirty-two-channel PCM sample player.
// Items enter on start while busy is low, with mode, offset, write_data and
// load_address. Memory loads and non-pitch register writes finish in the
// accepting cycle. A pitch write runs a 38-step restoring divider and holds
// busy until the quotient is committed. A sample tick walks the channels,
// each with a memory read and then an accumulate-and-advance step, and
// holds busy through a final done step; the mixed sample appears on the next cycle.
// A register read produces its result in the cycle after acceptance.
// Results appear for one cycle with strobe high; the receiver cannot
// stall, so nothing backs up. is_sample tells ticks from reads.
// Configuration: cfg_we, cfg_index (0 output_rate, 1 rom_words),
// cfg_data; write only while idle.
// Reset (rst, synchronous) clears all channel registers, key-on bits and
// the status word, and sets output_rate 44100 and rom_words 65536. Sample
// memory is not cleared; only loaded words may be played.
module multichannel_pcm_sample_player_top
  import mpsp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode,
  input  logic [10:0]        offset,
  input  logic [15:0]        write_data,
  input  logic [15:0]        load_address,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [16:0]        cfg_data,
  output logic               strobe,
  output logic               is_sample,
  output logic [15:0]        read_data,
  output logic signed [17:0] mixed_sample
);

  ctrl_t ctrl;
  stat_t stat;
  logic accept, pitch_write, tick;

  assign accept = start && !busy;
  assign pitch_write = (mode == MODE_WRITE) && offset[10] && (offset[4:0] == REG_PITCH)
                       && ({27'd0, offset[9:5]} < Channels);
  assign tick = (mode == MODE_TICK);

  mpsp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .pitch_write(pitch_write), .tick(tick),
    .stat(stat), .busy(busy), .ctrl(ctrl)
  );

  mpsp_datapath u_dp (
    .clk(clk), .rst(rst), .accept(accept), .mode(mode), .offset(offset),
    .write_data(write_data), .load_address(load_address), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .ctrl(ctrl), .stat(stat),
    .strobe(strobe), .is_sample(is_sample), .read_data(read_data),
    .mixed_sample(mixed_sample)
  );

  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit_tick |=> strobe && is_sample) else $error("tick result missing");
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    accept && mode == MODE_READ |=> strobe && !is_sample) else $error("read result missing");
  a_busy_tick: assert property (@(posedge clk) disable iff (rst)
    accept && tick |=> busy) else $error("tick not busy");
  a_div_commit: assert property (@(posedge clk) disable iff (rst)
    ctrl.div_commit |-> stat.div_done) else $error("early divide commit");

endmodule
